@@ sv/nrp_pkg.sv @@
// shared types, character codes and helpers for the netpbm raster parser
package nrp_pkg;

	// default dimension width in bits
	localparam int DIM_BITS_DEF = 16;

	// largest maxval accepted
	localparam logic [15:0] MAXVAL_MAX = 16'hFFFF;

	// character codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_P     = 8'h50;

	// pixel alpha and channels per rgb pixel
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam int RGB_CHANNELS = 3;

	// result kinds
	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_MAGIC     = 3'd1;
	localparam logic [2:0] ERR_BITMAP    = 3'd2;
	localparam logic [2:0] ERR_NUMBER    = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;

	// one input beat
	typedef struct packed {
		logic [7:0] data;
		logic       eof;
	} byte_beat_t;

	// one result beat
	typedef struct packed {
		kind_t       kind;
		logic [31:0] argb;
		logic [15:0] width;
		logic [15:0] height;
		logic        format;
		logic [2:0]  err;
		logic        last;
	} result_t;

	// space, tab, lf, vt, ff, cr
	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

@@ sv/nrp_in_stage.sv @@
// input register stage holding one file byte ahead of the parser
module nrp_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic [7:0]          data_byte,
	input  logic                end_of_file,
	input  logic                advance,
	output logic                valid_s1,
	output nrp_pkg::byte_beat_t beat_s1
);

	// hold the beat while the parser cannot advance
	assign byte_stall = valid_s1 && !advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			beat_s1.data <= data_byte;
			beat_s1.eof  <= end_of_file;
		end
	end

endmodule

@@ sv/nrp_parse.sv @@
// header and raster parser state with its one-byte update logic
module nrp_parse #(
	parameter int DIM_BITS = nrp_pkg::DIM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  nrp_pkg::byte_beat_t beat,
	output logic                res_valid,
	output nrp_pkg::result_t    res
);

	localparam int ACC_W = (DIM_BITS > 16) ? DIM_BITS : 16;
	localparam int NUM_W = ACC_W + 4;
	localparam logic [NUM_W-1:0] DIM_LIMIT = (NUM_W'(1) << DIM_BITS) - NUM_W'(1);
	localparam logic [NUM_W-1:0] MAXVAL_LIMIT = NUM_W'(nrp_pkg::MAXVAL_MAX);

	typedef enum logic [2:0] {
		PH_MAGIC_P,
		PH_MAGIC_DIGIT,
		PH_MAGIC_END,
		PH_HDR_SKIP,
		PH_HDR_NUM,
		PH_RASTER,
		PH_DONE,
		PH_ERROR
	} phase_t;

	phase_t              phase_q, phase_nx;
	logic                comment_q, comment_nx;
	logic [ACC_W-1:0]    acc_q, acc_nx;
	logic [1:0]          field_q, field_nx;
	logic [DIM_BITS-1:0] width_q, width_nx;
	logic [DIM_BITS-1:0] height_q, height_nx;
	logic                format_q, format_nx;
	logic [DIM_BITS-1:0] col_q, col_nx;
	logic [DIM_BITS-1:0] row_q, row_nx;
	logic [1:0]          chan_q, chan_nx;
	logic [7:0]          red_q, red_nx;
	logic [7:0]          green_q, green_nx;

	logic [7:0]       b;
	logic [NUM_W-1:0] num_v;
	logic [NUM_W-1:0] limit;
	logic             err_hit;
	logic [2:0]       err_code;
	logic             hdr_hit;
	logic             pix_hit;
	logic             pix_last;
	logic [23:0]      pix_rgb;

	assign b = beat.data;

	// next decimal value and its bound
	assign num_v = (NUM_W'(acc_q) << 3) + (NUM_W'(acc_q) << 1) + NUM_W'(b[3:0]);
	assign limit = (field_q < 2'd2) ? DIM_LIMIT : MAXVAL_LIMIT;

	// per-byte state update
	always_comb begin
		phase_nx   = phase_q;
		comment_nx = comment_q;
		acc_nx     = acc_q;
		field_nx   = field_q;
		width_nx   = width_q;
		height_nx  = height_q;
		format_nx  = format_q;
		col_nx     = col_q;
		row_nx     = row_q;
		chan_nx    = chan_q;
		red_nx     = red_q;
		green_nx   = green_q;
		err_hit    = 1'b0;
		err_code   = nrp_pkg::ERR_NONE;
		hdr_hit    = 1'b0;
		pix_hit    = 1'b0;
		pix_last   = 1'b0;
		pix_rgb    = '0;

		unique case (phase_q) inside
			PH_MAGIC_P, PH_HDR_SKIP: begin
				if (comment_q) begin
					if (b == nrp_pkg::CH_LF) begin
						comment_nx = 1'b0;
					end
				end else if (nrp_pkg::is_blank(b)) begin
					// skip whitespace
				end else if (b == nrp_pkg::CH_HASH) begin
					comment_nx = 1'b1;
				end else if (phase_q == PH_MAGIC_P) begin
					if (b != nrp_pkg::CH_P) begin
						err_hit  = 1'b1;
						err_code = nrp_pkg::ERR_MAGIC;
					end else begin
						phase_nx = PH_MAGIC_DIGIT;
					end
				end else if (!nrp_pkg::is_digit(b)) begin
					err_hit  = 1'b1;
					err_code = nrp_pkg::ERR_NUMBER;
				end else begin
					acc_nx   = ACC_W'(b[3:0]);
					phase_nx = PH_HDR_NUM;
				end
			end
			PH_MAGIC_DIGIT: begin
				if (b == nrp_pkg::CH_FOUR) begin
					err_hit  = 1'b1;
					err_code = nrp_pkg::ERR_BITMAP;
				end else if (b == nrp_pkg::CH_FIVE) begin
					format_nx = 1'b0;
					phase_nx  = PH_MAGIC_END;
				end else if (b == nrp_pkg::CH_SIX) begin
					format_nx = 1'b1;
					phase_nx  = PH_MAGIC_END;
				end else begin
					err_hit  = 1'b1;
					err_code = nrp_pkg::ERR_MAGIC;
				end
			end
			PH_MAGIC_END: begin
				if (b != nrp_pkg::CH_HASH && !nrp_pkg::is_blank(b)) begin
					err_hit  = 1'b1;
					err_code = nrp_pkg::ERR_MAGIC;
				end else begin
					comment_nx = (b == nrp_pkg::CH_HASH);
					field_nx   = 2'd0;
					phase_nx   = PH_HDR_SKIP;
				end
			end
			PH_HDR_NUM: begin
				if (nrp_pkg::is_digit(b)) begin
					if (num_v > limit) begin
						err_hit  = 1'b1;
						err_code = nrp_pkg::ERR_NUMBER;
					end else begin
						acc_nx = num_v[ACC_W-1:0];
					end
				end else if (field_q >= 2'd2) begin
					// maxval ends with exactly one whitespace byte
					if (!nrp_pkg::is_blank(b)) begin
						err_hit  = 1'b1;
						err_code = nrp_pkg::ERR_NUMBER;
					end else begin
						hdr_hit  = 1'b1;
						col_nx   = width_q;
						row_nx   = height_q;
						chan_nx  = 2'd0;
						phase_nx = (width_q != '0 && height_q != '0) ? PH_RASTER : PH_DONE;
					end
				end else if (b != nrp_pkg::CH_HASH && !nrp_pkg::is_blank(b)) begin
					err_hit  = 1'b1;
					err_code = nrp_pkg::ERR_NUMBER;
				end else begin
					comment_nx = (b == nrp_pkg::CH_HASH);
					if (field_q == 2'd0) begin
						width_nx = DIM_BITS'(acc_q);
					end else begin
						height_nx = DIM_BITS'(acc_q);
					end
					field_nx = field_q + 2'd1;
					acc_nx   = '0;
					phase_nx = PH_HDR_SKIP;
				end
			end
			PH_RASTER: begin
				if (!format_q) begin
					pix_hit = 1'b1;
					pix_rgb = {b, b, b};
				end else if (chan_q == 2'd0) begin
					red_nx  = b;
					chan_nx = 2'd1;
				end else if (chan_q == 2'd1) begin
					green_nx = b;
					chan_nx  = 2'd2;
				end else begin
					pix_hit = 1'b1;
					pix_rgb = {red_q, green_q, b};
					chan_nx = 2'd0;
				end
				// walk columns then rows
				if (pix_hit) begin
					if (col_q == DIM_BITS'(1)) begin
						if (row_q == DIM_BITS'(1)) begin
							pix_last = 1'b1;
							phase_nx = PH_DONE;
						end else begin
							row_nx = row_q - DIM_BITS'(1);
							col_nx = width_q;
						end
					end else begin
						col_nx = col_q - DIM_BITS'(1);
					end
				end
			end
			PH_DONE, PH_ERROR: begin
				// bytes are dropped until end of file
			end
		endcase

		if (err_hit) begin
			phase_nx = PH_ERROR;
		end

		// end of file: flag an unfinished image, then start over
		if (beat.eof) begin
			if (phase_nx != PH_DONE && phase_nx != PH_ERROR) begin
				err_hit  = 1'b1;
				err_code = nrp_pkg::ERR_TRUNCATED;
				hdr_hit  = 1'b0;
				pix_hit  = 1'b0;
			end
			phase_nx   = PH_MAGIC_P;
			comment_nx = 1'b0;
			acc_nx     = '0;
			field_nx   = 2'd0;
			width_nx   = '0;
			height_nx  = '0;
			format_nx  = 1'b0;
			col_nx     = '0;
			row_nx     = '0;
			chan_nx    = 2'd0;
			red_nx     = '0;
			green_nx   = '0;
		end
	end

	// result assembly
	always_comb begin
		res       = '0;
		res_valid = step && (err_hit || hdr_hit || pix_hit);
		if (err_hit) begin
			res.kind = nrp_pkg::KIND_ERROR;
			res.err  = err_code;
		end else if (hdr_hit) begin
			res.kind   = nrp_pkg::KIND_HEADER;
			res.width  = 16'(width_q);
			res.height = 16'(height_q);
			res.format = format_q;
		end else begin
			res.kind = nrp_pkg::KIND_PIXEL;
			res.argb = {nrp_pkg::ALPHA_OPAQUE, pix_rgb};
			res.last = pix_last;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MAGIC_P;
			comment_q <= 1'b0;
			acc_q     <= '0;
			field_q   <= 2'd0;
			width_q   <= '0;
			height_q  <= '0;
			format_q  <= 1'b0;
			col_q     <= '0;
			row_q     <= '0;
			chan_q    <= 2'd0;
			red_q     <= '0;
			green_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_nx;
			comment_q <= comment_nx;
			acc_q     <= acc_nx;
			field_q   <= field_nx;
			width_q   <= width_nx;
			height_q  <= height_nx;
			format_q  <= format_nx;
			col_q     <= col_nx;
			row_q     <= row_nx;
			chan_q    <= chan_nx;
			red_q     <= red_nx;
			green_q   <= green_nx;
		end
	end

endmodule

@@ sv/nrp_out_stage.sv @@
// result register that drives the output channel
module nrp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             res_valid,
	input  nrp_pkg::result_t res,
	output logic             advance,
	output logic             result_valid,
	input  logic             result_stall,
	output nrp_pkg::result_t res_q
);

	// the register can take a new beat when empty or being drained
	assign advance = !result_valid || !result_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= step && res_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (advance && step && res_valid) begin
			res_q <= res;
		end
	end

endmodule

@@ sv/netpbm_raster_parser_core.sv @@
// top level of the binary netpbm (p5/p6) raster parser
// path: input register, combinational parse, then the result register
// throughput: one byte per cycle while the output is not stalled
// a stalled output holds the result register and, through it, the input register
// reset: arst_n clears the parser to wait for the magic and empties both registers
// end_of_file on a byte returns the parser to the same start state after that byte
module netpbm_raster_parser_core #(
	parameter int DIM_BITS = nrp_pkg::DIM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  result_kind,
	output logic [31:0] pixel_argb,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        image_format,
	output logic [2:0]  error_code,
	output logic        last_pixel
);

	logic                valid_s1;
	nrp_pkg::byte_beat_t beat_s1;
	logic                advance;
	logic                step;
	logic                res_valid;
	nrp_pkg::result_t    res;
	nrp_pkg::result_t    res_q;

	assign step = valid_s1 && advance;

	// input register
	nrp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.end_of_file(end_of_file),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.beat_s1    (beat_s1)
	);

	// parser
	nrp_parse #(
		.DIM_BITS(DIM_BITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.beat     (beat_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// result register
	nrp_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.res_valid   (res_valid),
		.res         (res),
		.advance     (advance),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.res_q       (res_q)
	);

	// output fields
	assign result_kind  = res_q.kind;
	assign pixel_argb   = res_q.argb;
	assign image_width  = res_q.width;
	assign image_height = res_q.height;
	assign image_format = res_q.format;
	assign error_code   = res_q.err;
	assign last_pixel   = res_q.last;

endmodule

@@ tb/tb_top.sv @@
// testbench for the netpbm raster parser: scripted and random files checked against a predictor
module tb_top;
	import nrp_pkg::*;

	localparam int          HALF_PERIOD  = 4;
	localparam int          RESET_CYCLES = 9;
	localparam int          WATCHDOG_MAX = 5000;
	localparam int          DRAIN_CYCLES = 6;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          RANDOM_BYTES = 700;
	localparam int          MAX_REPORTS  = 10;
	localparam logic [31:0] DIM_LIMIT    = (32'd1 << DIM_BITS_DEF) - 32'd1;
	localparam logic [7:0]  CH_VT        = 8'h0B;
	localparam logic [7:0]  CH_FF        = 8'h0C;

	// predictor parse states
	typedef enum logic [3:0] {
		PS_MAGIC,
		PS_DIGIT,
		PS_MAGIC_END,
		PS_SKIP,
		PS_NUM,
		PS_RASTER,
		PS_DONE,
		PS_ERROR
	} parse_st_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        byte_valid   = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte    = 8'h00;
	logic        end_of_file  = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [31:0] pixel_argb;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        image_format;
	logic [2:0]  error_code;
	logic        last_pixel;

	netpbm_raster_parser_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.end_of_file  (end_of_file),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_kind  (result_kind),
		.pixel_argb   (pixel_argb),
		.image_width  (image_width),
		.image_height (image_height),
		.image_format (image_format),
		.error_code   (error_code),
		.last_pixel   (last_pixel)
	);

	// predictor state
	parse_st_t   parse_st;
	logic        in_cmt;
	logic [31:0] num_acc;
	logic [1:0]  field_idx;
	logic [15:0] hdr_width;
	logic [15:0] hdr_height;
	logic        hdr_rgb;
	logic [31:0] pixels_left;
	logic [1:0]  chan_idx;
	logic [7:0]  red_byte;
	logic [7:0]  green_byte;

	result_t     pending_results[$];
	logic [7:0]  file_q[$];

	int          idle_pct   = 0;
	int          stall_pct  = 0;
	int          hold_left  = 0;
	int          idle_run   = 0;
	int unsigned n_bytes    = 0;
	int unsigned n_files    = 0;
	int unsigned n_headers  = 0;
	int unsigned n_pixels   = 0;
	int unsigned n_errors   = 0;
	int unsigned n_mismatch = 0;
	result_t     want;

	always #HALF_PERIOD clk = ~clk;

	function automatic logic blank_chr(input logic [7:0] b);
		case (b)
			CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic digit_chr(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic [7:0] blank_pick();
		case ($urandom_range(5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	task automatic clear_parse();
		parse_st    = PS_MAGIC;
		in_cmt      = 1'b0;
		num_acc     = '0;
		field_idx   = '0;
		hdr_width   = '0;
		hdr_height  = '0;
		hdr_rgb     = 1'b0;
		pixels_left = '0;
		chan_idx    = '0;
		red_byte    = '0;
		green_byte  = '0;
	endtask

	function automatic result_t error_beat(input logic [2:0] code);
		result_t e;
		e        = '0;
		e.kind   = KIND_ERROR;
		e.err    = code;
		parse_st = PS_ERROR;
		return e;
	endfunction

	function automatic result_t pixel_beat(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		result_t p;
		p           = '0;
		p.kind      = KIND_PIXEL;
		p.argb      = {ALPHA_OPAQUE, r, g, b};
		pixels_left = pixels_left - 32'd1;
		if (pixels_left == 0) begin
			p.last   = 1'b1;
			parse_st = PS_DONE;
		end
		return p;
	endfunction

	// advance the parser model by one accepted byte and queue what it yields
	task automatic parse_byte(input logic [7:0] b, input logic eof);
		result_t     r;
		logic        hit;
		logic [31:0] v;
		logic [31:0] lim;
		r   = '0;
		hit = 1'b0;
		case (parse_st)
			PS_MAGIC, PS_SKIP: begin
				if (in_cmt) begin
					if (b == CH_LF)
						in_cmt = 1'b0;
				end else if (b == CH_HASH) begin
					in_cmt = 1'b1;
				end else if (!blank_chr(b)) begin
					if (parse_st == PS_MAGIC) begin
						if (b != CH_P) begin
							r   = error_beat(ERR_MAGIC);
							hit = 1'b1;
						end else begin
							parse_st = PS_DIGIT;
						end
					end else if (!digit_chr(b)) begin
						r   = error_beat(ERR_NUMBER);
						hit = 1'b1;
					end else begin
						num_acc  = 32'(b - CH_ZERO);
						parse_st = PS_NUM;
					end
				end
			end
			PS_DIGIT: begin
				if (b == CH_FOUR) begin
					r   = error_beat(ERR_BITMAP);
					hit = 1'b1;
				end else if (b == CH_FIVE || b == CH_SIX) begin
					hdr_rgb  = (b == CH_SIX);
					parse_st = PS_MAGIC_END;
				end else begin
					r   = error_beat(ERR_MAGIC);
					hit = 1'b1;
				end
			end
			PS_MAGIC_END: begin
				if (b == CH_HASH || blank_chr(b)) begin
					in_cmt    = (b == CH_HASH);
					field_idx = '0;
					parse_st  = PS_SKIP;
				end else begin
					r   = error_beat(ERR_MAGIC);
					hit = 1'b1;
				end
			end
			PS_NUM: begin
				lim = (field_idx < 2) ? DIM_LIMIT : {16'd0, MAXVAL_MAX};
				if (digit_chr(b)) begin
					v = num_acc * 32'd10 + 32'(b - CH_ZERO);
					if (v > lim) begin
						r   = error_beat(ERR_NUMBER);
						hit = 1'b1;
					end else begin
						num_acc = v;
					end
				end else if (field_idx >= 2) begin
					hit = 1'b1;
					if (!blank_chr(b)) begin
						r = error_beat(ERR_NUMBER);
					end else begin
						r.kind      = KIND_HEADER;
						r.width     = hdr_width;
						r.height    = hdr_height;
						r.format    = hdr_rgb;
						pixels_left = 32'(hdr_width) * 32'(hdr_height);
						chan_idx    = '0;
						parse_st    = (pixels_left != 0) ? PS_RASTER : PS_DONE;
					end
				end else if (b != CH_HASH && !blank_chr(b)) begin
					r   = error_beat(ERR_NUMBER);
					hit = 1'b1;
				end else begin
					in_cmt = (b == CH_HASH);
					if (field_idx == 0)
						hdr_width = num_acc[15:0];
					else
						hdr_height = num_acc[15:0];
					field_idx = field_idx + 2'd1;
					num_acc   = '0;
					parse_st  = PS_SKIP;
				end
			end
			PS_RASTER: begin
				if (!hdr_rgb) begin
					r   = pixel_beat(b, b, b);
					hit = 1'b1;
				end else if (chan_idx == 0) begin
					red_byte = b;
					chan_idx = 2'd1;
				end else if (chan_idx == 1) begin
					green_byte = b;
					chan_idx   = 2'd2;
				end else begin
					chan_idx = '0;
					r        = pixel_beat(red_byte, green_byte, b);
					hit      = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// end of file: unfinished image is flagged, then everything restarts
		if (eof) begin
			if (parse_st != PS_DONE && parse_st != PS_ERROR) begin
				r   = error_beat(ERR_TRUNCATED);
				hit = 1'b1;
			end
			clear_parse();
		end
		if (hit)
			pending_results.push_back(r);
	endtask

	// offer one beat, with random gaps, and wait until it is taken
	task automatic send_byte(input logic [7:0] b, input logic eof);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			byte_valid <= 1'b0;
		end
		@(negedge clk);
		byte_valid  <= 1'b1;
		data_byte   <= b;
		end_of_file <= eof;
		do
			@(posedge clk);
		while (byte_stall);
		parse_byte(b, eof);
		n_bytes++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		file_q.push_back(b);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			file_q.push_back(s[i]);
	endtask

	task automatic put_num(input int unsigned n);
		if ($urandom_range(9) == 0)
			put_byte(CH_ZERO);
		put_str($sformatf("%0d", n));
	endtask

	// token separator: blanks and sometimes a comment with arbitrary content
	task automatic put_sep();
		logic [7:0] c;
		if ($urandom_range(99) < 25) begin
			put_byte(CH_HASH);
			repeat ($urandom_range(6)) begin
				c = 8'($urandom_range(255));
				put_byte((c == CH_LF) ? CH_SPACE : c);
			end
			put_byte(CH_LF);
		end else begin
			put_byte(blank_pick());
		end
		repeat ($urandom_range(2))
			put_byte(blank_pick());
	endtask

	// send the built file, end_of_file on its last byte
	task automatic send_file();
		foreach (file_q[i])
			send_byte(file_q[i], i == file_q.size() - 1);
		file_q.delete();
		n_files++;
	endtask

	// mostly well-formed files with random content, some noise and damage
	task automatic build_random_file();
		int unsigned roll;
		int unsigned w;
		int unsigned h;
		int unsigned mv;
		int unsigned n_raster;
		int unsigned keep;
		int unsigned hdr_len;
		logic        rgb;
		roll = $urandom_range(99);
		if (roll < 6) begin
			repeat ($urandom_range(12, 1))
				put_byte(8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(3) == 0)
			put_sep();
		put_byte(CH_P);
		rgb = 1'($urandom_range(1));
		if ($urandom_range(99) < 4)
			put_byte(8'($urandom_range(255)));
		else
			put_byte(rgb ? CH_SIX : CH_FIVE);
		put_sep();
		roll = $urandom_range(99);
		if (roll < 80) begin
			w = $urandom_range(4);
			h = $urandom_range(4);
		end else if (roll < 94) begin
			w = $urandom_range(24, 5);
			h = $urandom_range(2, 1);
		end else begin
			w = $urandom_range(DIM_LIMIT + 1, DIM_LIMIT - 3);
			h = $urandom_range(1);
		end
		put_num(w);
		put_sep();
		put_num(h);
		put_sep();
		mv = ($urandom_range(99) < 3) ? 65536 : $urandom_range(65535, 1);
		put_num(mv);
		if ($urandom_range(99) < 4)
			put_byte(8'($urandom_range(255)));
		else
			put_byte(blank_pick());
		hdr_len  = file_q.size();
		n_raster = w * h * (rgb ? 3 : 1);
		keep     = n_raster;
		if (n_raster > 64 || $urandom_range(99) < 10)
			keep = $urandom_range((n_raster < 40) ? n_raster : 40);
		repeat (keep)
			put_byte(8'($urandom_range(255)));
		if ($urandom_range(99) < 10)
			repeat ($urandom_range(3, 1))
				put_byte(8'($urandom_range(255)));
		if ($urandom_range(99) < 10)
			file_q[$urandom_range(hdr_len - 1)] = 8'($urandom_range(255));
	endtask

	// magic errors: wrong letter, bitmap, bad digit, junk after digit, cut after p
	task automatic test_magic_errors();
		put_str("Q");
		send_file();
		put_str("P4 1 1 1\n");
		send_file();
		put_str("P7");
		send_file();
		put_str("P5x");
		send_file();
		put_str("P");
		send_file();
	endtask

	// comments and every blank between tokens, rgb and gray rasters, empty raster
	task automatic test_header_forms();
		put_str(" \t#c\nP6#x\n2");
		put_byte(CH_VT);
		put_str("1#z\n");
		put_byte(CH_FF);
		put_str("255");
		put_byte(CH_CR);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h80);
		put_byte(8'h7F);
		put_byte(8'h01);
		put_byte(8'hFE);
		send_file();
		put_str("P5 1#n\n2 255\n");
		put_byte(8'h00);
		put_byte(8'hFF);
		send_file();
		put_str("P5 0 7 255\nab");
		send_file();
	endtask

	// largest legal numbers and every way a number can go wrong
	task automatic test_number_limits();
		put_str("P5 65535 0 65535\n");
		send_file();
		put_str("P5 65536 1 1\n");
		send_file();
		put_str("P5 1 65536");
		send_file();
		put_str("P5 1 1 65536");
		send_file();
		put_str("P5 1 1 255#");
		send_file();
		put_str("P5 a");
		send_file();
		put_str("P5 12a");
		send_file();
	endtask

	// end of file inside the raster, on the header byte and inside a number
	task automatic test_truncation();
		put_str("P5 2 2 255\nxy");
		send_file();
		put_str("P6 1 1 255\n");
		send_file();
		put_str("P5 1 1");
		send_file();
	endtask

	// output held off for a long stretch while the input keeps coming
	task automatic test_backpressure();
		hold_left = HOLD_CYCLES;
		put_str("P5 8 5 255\n");
		repeat (40)
			put_byte(8'($urandom_range(255)));
		send_file();
	endtask

	// random files under each idle mix
	task automatic test_random();
		int          m;
		int unsigned start;
		for (m = 0; m < 4; m++) begin
			case (m)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 79;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 79;
				end
				default: begin
					idle_pct  = 7;
					stall_pct = 7;
				end
			endcase
			start = n_bytes;
			while (n_bytes - start < RANDOM_BYTES / 4) begin
				build_random_file();
				send_file();
			end
		end
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	// output side stall: long hold-off when asked for, else random
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			case (result_kind)
				KIND_HEADER: n_headers++;
				KIND_PIXEL:  n_pixels++;
				default:     n_errors++;
			endcase
			if (pending_results.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= MAX_REPORTS)
					$display("unexpected result: kind %0d argb %h err %0d",
						result_kind, pixel_argb, error_code);
			end else begin
				want = pending_results.pop_front();
				if (result_kind !== want.kind || pixel_argb !== want.argb ||
						image_width !== want.width || image_height !== want.height ||
						image_format !== want.format || error_code !== want.err ||
						last_pixel !== want.last) begin
					n_mismatch++;
					if (n_mismatch <= MAX_REPORTS) begin
						$display("mismatch (exp/got): kind %0d/%0d argb %h/%h w %0d/%0d",
							want.kind, result_kind, want.argb, pixel_argb,
							want.width, image_width);
						$display("  h %0d/%0d fmt %0d/%0d err %0d/%0d last %0d/%0d",
							want.height, image_height, want.format, image_format,
							want.err, error_code, want.last, last_pixel);
					end
				end
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
			idle_run = 0;
		else
			idle_run = idle_run + 1;
		if (idle_run >= WATCHDOG_MAX) begin
			$display("timeout: no beat moved for %0d cycles", WATCHDOG_MAX);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		clear_parse();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		test_magic_errors();
		test_header_forms();
		test_number_limits();
		test_truncation();
		test_backpressure();
		test_random();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d files, %0d bytes in; %0d headers, %0d pixels, %0d errors out",
			n_files, n_bytes, n_headers, n_pixels, n_errors);
		$display("flow mixes: free, input gaps, output stalls, light both, long hold-off");
		if (n_mismatch == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d results never seen", n_mismatch,
				pending_results.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
